// ===== rtl/tkx_pkg.sv =====
package tkx_pkg;

   localparam int LEN_A         = 93;
   localparam int LEN_B         = 84;
   localparam int LEN_C         = 111;
   localparam int KEY_BITS      = 80;
   localparam int BYTE_BITS     = 8;
   localparam int WARMUP_ROUNDS = 1152;
   // One core step runs as many rounds as a byte has bits.
   localparam int WARMUP_STEPS  = WARMUP_ROUNDS / BYTE_BITS;
   localparam int WARM_CNT_BITS = $clog2(WARMUP_STEPS);
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 3;
   localparam int HIGH_BITS     = KEY_BITS - CSR_DATA_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_KEY_LOW  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_KEY_HIGH = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IV_LOW   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_IV_HIGH  = 3'd3;

   typedef struct packed {
      logic [LEN_A-1:0] a;
      logic [LEN_B-1:0] b;
      logic [LEN_C-1:0] c;
   } cipher_state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [KEY_BITS-1:0] iv;
   } cipher_cfg_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 new_message;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [1:0] {
      CORE_READY,
      CORE_WARMUP,
      CORE_FIRST
   } core_state_type;

   function automatic logic keystream_bit(input cipher_state_type s);
      keystream_bit = s.a[65] ^ s.a[92] ^ s.b[68] ^ s.b[83] ^ s.c[65] ^ s.c[110];
   endfunction

   function automatic cipher_state_type round_step(input cipher_state_type s);
      logic t1;
      logic t2;
      logic t3;
      cipher_state_type r;
      t1 = s.a[65] ^ s.a[92] ^ (s.a[90] & s.a[91]) ^ s.b[77];
      t2 = s.b[68] ^ s.b[83] ^ (s.b[81] & s.b[82]) ^ s.c[86];
      t3 = s.c[65] ^ s.c[110] ^ (s.c[108] & s.c[109]) ^ s.a[68];
      r.a = {s.a[LEN_A-2:0], t3};
      r.b = {s.b[LEN_B-2:0], t1};
      r.c = {s.c[LEN_C-2:0], t2};
      round_step = r;
   endfunction

   function automatic cipher_state_type load_state(input cipher_cfg_type cfg);
      cipher_state_type r;
      r.a = {{(LEN_A-KEY_BITS){1'b0}}, cfg.key};
      r.b = {{(LEN_B-KEY_BITS){1'b0}}, cfg.iv};
      r.c = {3'b111, {(LEN_C-3){1'b0}}};
      load_state = r;
   endfunction

endpackage

// ===== rtl/tkx_front.sv =====
module tkx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tkx_pkg::item_type     req_item,
   output tkx_pkg::queue_head_type head,
   input  logic                  pop
);

   tkx_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       do_pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== rtl/tkx_core.sv =====
module tkx_core (
   input  logic                           clock,
   input  logic                           reset,
   input  tkx_pkg::cipher_cfg_type        cfg,
   input  tkx_pkg::queue_head_type        head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tkx_pkg::BYTE_BITS-1:0]  rsp_out_byte
);

   tkx_pkg::core_state_type  fsm_ff;
   tkx_pkg::core_state_type  fsm_in;
   tkx_pkg::cipher_state_type cs_ff;
   tkx_pkg::cipher_state_type cs_in;
   tkx_pkg::cipher_state_type stepped;
   logic [tkx_pkg::WARM_CNT_BITS-1:0] warm_cnt_ff;
   logic [tkx_pkg::WARM_CNT_BITS-1:0] warm_cnt_in;
   logic [tkx_pkg::BYTE_BITS-1:0]     keystream;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [tkx_pkg::BYTE_BITS-1:0]     rsp_byte_ff;
   logic                              slot_free;
   logic                              last_warm;
   logic                              load;
   logic                              advance;
   logic                              emit;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_warm = (warm_cnt_ff == tkx_pkg::WARM_CNT_BITS'(tkx_pkg::WARMUP_STEPS - 1));

   // Eight rounds per cycle whenever the state advances; the first keystream bit lands on the top bit.
   always_comb begin
      tkx_pkg::cipher_state_type s;
      s = cs_ff;
      keystream = '0;
      for (int i = 0; i < tkx_pkg::BYTE_BITS; i++) begin
         keystream[tkx_pkg::BYTE_BITS-1-i] = tkx_pkg::keystream_bit(s);
         s = tkx_pkg::round_step(s);
      end
      stepped = s;
   end

   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         tkx_pkg::CORE_READY: begin
            if (head.valid && head.item.new_message) begin
               fsm_in = tkx_pkg::CORE_WARMUP;
            end
         end
         tkx_pkg::CORE_WARMUP: begin
            if (last_warm) begin
               fsm_in = tkx_pkg::CORE_FIRST;
            end
         end
         tkx_pkg::CORE_FIRST: begin
            if (slot_free) begin
               fsm_in = tkx_pkg::CORE_READY;
            end
         end
         default: fsm_in = tkx_pkg::CORE_READY;
      endcase
   end

   always_comb begin
      load    = 1'b0;
      advance = 1'b0;
      emit    = 1'b0;
      unique case (fsm_ff)
         tkx_pkg::CORE_READY: begin
            load = head.valid && head.item.new_message;
            emit = head.valid && !head.item.new_message && slot_free;
         end
         tkx_pkg::CORE_WARMUP: begin
            advance = 1'b1;
         end
         tkx_pkg::CORE_FIRST: begin
            // The head byte has been warmed up already, so its flag is ignored.
            emit = slot_free;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign pop = emit;

   always_comb begin
      cs_in       = cs_ff;
      warm_cnt_in = warm_cnt_ff;
      if (load) begin
         cs_in       = tkx_pkg::load_state(cfg);
         warm_cnt_in = '0;
      end else if (advance || emit) begin
         cs_in = stepped;
      end
      if (advance) begin
         warm_cnt_in = warm_cnt_ff + 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= tkx_pkg::CORE_READY;
         cs_ff        <= '0;
         warm_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         cs_ff        <= cs_in;
         warm_cnt_ff  <= warm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= head.item.data_byte ^ keystream;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

endmodule

// ===== rtl/trivium_keystream_xor.sv =====
// Trivium stream cipher (80-bit key, 80-bit IV) that XORs its keystream onto
// a byte stream; encryption and decryption are the same operation. Key and IV
// are to be written through the csr_ port while the block is idle, which the
// block does not enforce; they take effect at the next beat with
// req_new_message set. Such a beat reloads the state and runs 1152 warm-up
// rounds, eight per cycle, before its result; every other byte is XORed with
// the keystream of the eight unrolled rounds in the cipher core. A two-entry
// queue in front of the core keeps accepting beats while it has room, also
// while the core warms up or the result register waits. Bytes sent before any
// new message use the reset state, whose keystream is zero.
module trivium_keystream_xor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_new_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   logic [tkx_pkg::CSR_DATA_BITS-1:0] key_low_ff;
   logic [tkx_pkg::HIGH_BITS-1:0]     key_high_ff;
   logic [tkx_pkg::CSR_DATA_BITS-1:0] iv_low_ff;
   logic [tkx_pkg::HIGH_BITS-1:0]     iv_high_ff;
   tkx_pkg::cipher_cfg_type  cfg;
   tkx_pkg::item_type        req_item;
   tkx_pkg::queue_head_type  head;
   logic                     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         iv_low_ff   <= '0;
         iv_high_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            tkx_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            tkx_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata[tkx_pkg::HIGH_BITS-1:0];
            tkx_pkg::CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
            tkx_pkg::CSR_IV_HIGH:  iv_high_ff  <= csr_wdata[tkx_pkg::HIGH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.key = {key_high_ff, key_low_ff};
   assign cfg.iv  = {iv_high_ff, iv_low_ff};

   assign req_item.data_byte   = req_data_byte;
   assign req_item.new_message = req_new_message;

   tkx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   tkx_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int TIMEOUT_NS    = 2000000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_BYTES  = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int CSR_REG_COUNT = 4;
   localparam int CSR_ADDR_MAX  = 7;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_new_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [63:0] csr_wdata = '0;

   trivium_keystream_xor uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_new_message (req_new_message),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   // Cipher state and key/IV as the testbench expects them to be.
   logic [tkx_pkg::LEN_A-1:0]    reg_a = '0;
   logic [tkx_pkg::LEN_B-1:0]    reg_b = '0;
   logic [tkx_pkg::LEN_C-1:0]    reg_c = '0;
   logic [tkx_pkg::KEY_BITS-1:0] key_mirror = '0;
   logic [tkx_pkg::KEY_BITS-1:0] iv_mirror = '0;

   tkx_pkg::item_type pending_bytes[$];
   logic [7:0]  expected_out[$];
   int          failures = 0;
   int          holds_asked = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // One Trivium round on the mirrored state; returns the keystream bit.
   function automatic logic clock_cipher();
      logic ta;
      logic tb;
      logic tc;
      logic z;
      ta = reg_a[65] ^ reg_a[92];
      tb = reg_b[68] ^ reg_b[83];
      tc = reg_c[65] ^ reg_c[110];
      z  = ta ^ tb ^ tc;
      ta = ta ^ (reg_a[90] & reg_a[91]) ^ reg_b[77];
      tb = tb ^ (reg_b[81] & reg_b[82]) ^ reg_c[86];
      tc = tc ^ (reg_c[108] & reg_c[109]) ^ reg_a[68];
      reg_a = {reg_a[tkx_pkg::LEN_A-2:0], tc};
      reg_b = {reg_b[tkx_pkg::LEN_B-2:0], ta};
      reg_c = {reg_c[tkx_pkg::LEN_C-2:0], tb};
      return z;
   endfunction

   function automatic logic [7:0] cipher_byte(input logic [7:0] data, input logic restart);
      logic [7:0] stream;
      logic       discard;
      if (restart) begin
         reg_a = '0;
         reg_b = '0;
         reg_c = '0;
         reg_a[tkx_pkg::KEY_BITS-1:0] = key_mirror;
         reg_b[tkx_pkg::KEY_BITS-1:0] = iv_mirror;
         reg_c[tkx_pkg::LEN_C-1:tkx_pkg::LEN_C-3] = 3'b111;
         for (int i = 0; i < tkx_pkg::WARMUP_ROUNDS; i++) begin
            discard = clock_cipher();
         end
      end
      for (int i = 0; i < tkx_pkg::BYTE_BITS; i++) begin
         stream[tkx_pkg::BYTE_BITS-1-i] = clock_cipher();
      end
      return data ^ stream;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int send_burst = 0;
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_out.push_back(cipher_byte(req_data_byte, req_new_message));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_valid       <= 1'b1;
               req_data_byte   <= pending_bytes[0].data_byte;
               req_new_message <= pending_bytes[0].new_message;
               void'(pending_bytes.pop_front());
               if (send_burst > 0) begin
                  send_burst = send_burst - 1;
               end else begin
                  send_burst = $urandom_range(0, 24);
                  // Half of the bursts are followed by no gap at all.
                  send_gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern chosen at random from four modes; a long hold on request.
   int rx_cycle = 0;
   int rx_mode = 0;
   int hold_left = 0;
   int holds_served = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_served + 1;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rx_cycle % 128 == 0) begin
            rx_mode = $urandom_range(0, 3);
         end
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_cycle % 4 != 0);
         endcase
      end
   end

   // Result checker.
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            $error("out_byte: expected none, actual %02h", rsp_out_byte);
            failures = failures + 1;
         end else begin
            want = expected_out.pop_front();
            if (rsp_out_byte !== want) begin
               $error("out_byte: expected %02h, actual %02h", want, rsp_out_byte);
               failures = failures + 1;
            end
         end
      end
   end

   task automatic write_csr(input logic [2:0] index, input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      case (index)
         tkx_pkg::CSR_KEY_LOW:
            key_mirror[tkx_pkg::CSR_DATA_BITS-1:0] = value;
         tkx_pkg::CSR_KEY_HIGH:
            key_mirror[tkx_pkg::KEY_BITS-1:tkx_pkg::CSR_DATA_BITS] =
               value[tkx_pkg::HIGH_BITS-1:0];
         tkx_pkg::CSR_IV_LOW:
            iv_mirror[tkx_pkg::CSR_DATA_BITS-1:0] = value;
         tkx_pkg::CSR_IV_HIGH:
            iv_mirror[tkx_pkg::KEY_BITS-1:tkx_pkg::CSR_DATA_BITS] =
               value[tkx_pkg::HIGH_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_key_iv(input logic [63:0] key_lo, input logic [63:0] key_hi,
                              input logic [63:0] iv_lo, input logic [63:0] iv_hi);
      write_csr(tkx_pkg::CSR_KEY_LOW, key_lo);
      write_csr(tkx_pkg::CSR_KEY_HIGH, key_hi);
      write_csr(tkx_pkg::CSR_IV_LOW, iv_lo);
      write_csr(tkx_pkg::CSR_IV_HIGH, iv_hi);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic restart);
      tkx_pkg::item_type entry;
      entry.data_byte   = data;
      entry.new_message = restart;
      pending_bytes.push_back(entry);
   endtask

   // The sender has nothing left and every expected byte has come back.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_bytes.size() != 0 || req_valid || expected_out.size() != 0);
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int generated;
      int phase;
      int msgs;
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Before any message the state is all zeros, so bytes pass unchanged.
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hA5, 1'b0);
      // Zero key and IV.
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      wait_idle();

      // All-ones key and IV; the high registers get extra bits that must be dropped.
      load_key_iv('1, '1, '1, '1);
      write_csr(3'(CSR_REG_COUNT), {$urandom, $urandom});
      write_csr(3'(CSR_ADDR_MAX), '1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h55, 1'b1);
      queue_byte(8'hAA, 1'b0);
      wait_idle();

      // Mixed halves, then two restarts in a row.
      load_key_iv('0, 64'hFFFF, '1, '0);
      queue_byte(8'h7F, 1'b1);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      generated = 0;
      phase = 0;
      while (generated < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) == 0) begin
            write_csr(3'($urandom_range(CSR_REG_COUNT, CSR_ADDR_MAX)), {$urandom, $urandom});
         end
         if ($urandom_range(0, 4) == 0) begin
            // Change only one register; the others keep their old values.
            write_csr(3'($urandom_range(0, CSR_REG_COUNT - 1)), random_word());
         end else begin
            load_key_iv(random_word(), random_word(), random_word(), random_word());
         end
         if (phase == 3) begin
            holds_asked = holds_asked + 1;
         end
         // New key and IV must not matter until the next restart.
         if ($urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            generated = generated + len;
         end
         msgs = $urandom_range(1, 4);
         for (int m = 0; m < msgs; m++) begin
            len = (phase == 3) ? 40 : $urandom_range(0, 30);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            for (int i = 0; i < len; i++) begin
               // Occasionally a restart breaks into the middle of a message.
               queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end
            generated = generated + len + 1;
         end
         wait_idle();
         phase = phase + 1;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && expected_out.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
